FILE: rtl/core/rlac_pkg.sv
// Shared types, codes and reset values of the remote link arming controller.
`timescale 1ns / 1ps

package rlac_pkg;

    localparam int unsigned HeadWidth   = 8;
    localparam int unsigned StickWidth  = 16;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned HoldWidth   = 8;
    localparam int unsigned RelockWidth = 14;
    localparam int unsigned MissWidth   = 8;

    localparam int unsigned InDataWidth  = 104;
    localparam int unsigned OutDataWidth = 80;
    localparam int unsigned CfgIdxWidth  = 3;
    localparam int unsigned CfgDataWidth = 16;

    // register indexes of the configuration port
    localparam logic [CfgIdxWidth-1:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_HEADER_THIRD  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_HIGH_THRESH   = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_LOW_THRESH    = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CFG_HOLD_TICKS    = 3'd5;
    localparam logic [CfgIdxWidth-1:0] CFG_RELOCK_TICKS  = 3'd6;
    localparam logic [CfgIdxWidth-1:0] CFG_LINK_TIMEOUT  = 3'd7;

    localparam logic [StickWidth-1:0]  RST_HIGH_THRESH  = 16'd960;
    localparam logic [StickWidth-1:0]  RST_LOW_THRESH   = 16'd20;
    localparam logic [HoldWidth-1:0]   RST_HOLD_TICKS   = 8'd200;
    localparam logic [RelockWidth-1:0] RST_RELOCK_TICKS = 14'd10000;
    localparam logic [MissWidth-1:0]   RST_LINK_TIMEOUT = 8'd200;
    localparam logic [MissWidth-1:0]   RST_MISS_COUNT   = 8'd200;

    typedef enum logic [4:0] {
        PH_FREE  = 5'b00001,
        PH_HIGH  = 5'b00010,
        PH_LEAVE = 5'b00100,
        PH_LOW   = 5'b01000,
        PH_ARMED = 5'b10000
    } arm_phase_t;

    // per-tick request from the step logic to the arming machine
    typedef struct packed {
        logic step;
        logic link;
        logic hi;
        logic lo;
    } arm_ctrl_t;

endpackage

FILE: rtl/core/rlac_arm.sv
// Arming state machine with its hold and disarm counters.
`timescale 1ns / 1ps

module rlac_arm
    import rlac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  arm_ctrl_t              ctrl,
    input  logic [HoldWidth-1:0]   hold_ticks,
    input  logic [RelockWidth-1:0] relock_ticks,
    output logic                   armed
);

    arm_phase_t             phase_reg, phase_next;
    logic [HoldWidth-1:0]   high_cnt_reg, high_cnt_next;
    logic [HoldWidth-1:0]   low_cnt_reg, low_cnt_next;
    logic [RelockWidth-1:0] disarm_cnt_reg, disarm_cnt_next;
    logic [HoldWidth-1:0]   high_inc, low_inc;
    logic [RelockWidth-1:0] disarm_inc;

    assign high_inc   = (high_cnt_reg == '1) ? high_cnt_reg : high_cnt_reg + 1'b1;
    assign low_inc    = (low_cnt_reg == '1) ? low_cnt_reg : low_cnt_reg + 1'b1;
    assign disarm_inc = (disarm_cnt_reg == '1) ? disarm_cnt_reg : disarm_cnt_reg + 1'b1;

    // armed reports the phase at the start of the step, forced low while the link is lost
    assign armed = ctrl.link && (phase_reg == PH_ARMED);

    always_comb
    begin
        phase_next      = phase_reg;
        high_cnt_next   = high_cnt_reg;
        low_cnt_next    = low_cnt_reg;
        disarm_cnt_next = disarm_cnt_reg;
        if (!ctrl.link)
        begin
            phase_next = PH_FREE;
        end
        else
        begin
            case (phase_reg)
                PH_FREE:
                begin
                    high_cnt_next = '0;
                    low_cnt_next  = '0;
                    if (ctrl.hi)
                        phase_next = PH_HIGH;
                end
                PH_HIGH:
                begin
                    if (ctrl.hi)
                    begin
                        high_cnt_next = high_inc;
                        if (high_inc >= hold_ticks)
                            phase_next = PH_LEAVE;
                    end
                    else
                        phase_next = PH_FREE;
                end
                PH_LEAVE:
                begin
                    if (ctrl.lo)
                        phase_next = PH_LOW;
                end
                PH_LOW:
                begin
                    if (ctrl.lo)
                    begin
                        low_cnt_next = low_inc;
                        if (low_inc >= hold_ticks)
                            phase_next = PH_ARMED;
                    end
                    else
                        phase_next = PH_FREE;
                end
                PH_ARMED:
                begin
                    if (ctrl.lo)
                    begin
                        if (disarm_inc >= relock_ticks)
                        begin
                            phase_next      = PH_FREE;
                            disarm_cnt_next = '0;
                        end
                        else
                            disarm_cnt_next = disarm_inc;
                    end
                    else
                        disarm_cnt_next = '0;
                end
                default:
                begin
                    phase_next = PH_FREE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FREE;
            high_cnt_reg   <= '0;
            low_cnt_reg    <= '0;
            disarm_cnt_reg <= '0;
        end
        else if (ctrl.step)
        begin
            phase_reg      <= phase_next;
            high_cnt_reg   <= high_cnt_next;
            low_cnt_reg    <= low_cnt_next;
            disarm_cnt_reg <= disarm_cnt_next;
        end
    end

endmodule

FILE: rtl/core/remote_link_arming_controller.sv
// Top level: input register, one-tick step logic, result register, config registers.
`timescale 1ns / 1ps

// One control tick enters per request on the s_ group and one result leaves on
// the m_ group. Throughput is one tick per clock cycle while m_tready is high.
// An accepted tick sits in the input register, is then stepped into the
// result register, and its result is valid on m_ from then on. All
// state (latched sticks, fix-height flag, link watchdog, arming machine) is
// updated by the same step that moves a tick from the input register into
// the result register, so consecutive ticks see each other's effects. The
// result register holds while m_tready is low; an empty input register still
// takes one more tick, after which s_tready stays low until the result leaves.
// Configuration writes on cfg_ are always ready and take effect from the next
// tick; write them while the block is idle.
module remote_link_arming_controller
    import rlac_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [7:0] frame_head0, [15:8] frame_head1, [23:16] frame_head2,
    // [39:24] throttle_in, [55:40] yaw_in, [71:56] pitch_in, [87:72] roll_in,
    // [95:88] power_down_in, [103:96] mode_toggle_in
    input  logic [InDataWidth-1:0]  s_tdata,
    // [0] frame_present
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [0] frame_accepted, [1] link_ok, [2] armed, [3] fix_height,
    // [19:4] throttle_out, [35:20] yaw_out, [51:36] pitch_out,
    // [67:52] roll_out, [75:68] power_down_out, [79:76] zero
    output logic [OutDataWidth-1:0] m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data
);

    // configuration
    logic [HeadWidth-1:0]   hdr0_reg, hdr1_reg, hdr2_reg;
    logic [StickWidth-1:0]  high_thr_reg, low_thr_reg;
    logic [HoldWidth-1:0]   hold_reg;
    logic [RelockWidth-1:0] relock_reg;
    logic [MissWidth-1:0]   timeout_reg;

    // input register
    logic                   in_valid_reg;
    logic                   in_present_reg;
    logic [InDataWidth-1:0] in_data_reg;

    // result register
    logic                    out_valid_reg;
    logic [OutDataWidth-1:0] out_data_reg, out_data_next;

    // tick state
    logic [StickWidth-1:0] thr_reg, yaw_reg, pitch_reg, roll_reg;
    logic [StickWidth-1:0] thr_next, yaw_next, pitch_next, roll_next;
    logic [ByteWidth-1:0]  pd_reg, pd_next;
    logic                  flag_reg, flag_next, flag_parsed;
    logic [MissWidth-1:0]  miss_reg, miss_next, miss_inc;

    logic                  step;
    logic                  accepted;
    logic                  link;
    logic                  armed;
    arm_ctrl_t             arm_ctrl;

    assign cfg_ready = 1'b1;
    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr0_reg     <= '0;
            hdr1_reg     <= '0;
            hdr2_reg     <= '0;
            high_thr_reg <= RST_HIGH_THRESH;
            low_thr_reg  <= RST_LOW_THRESH;
            hold_reg     <= RST_HOLD_TICKS;
            relock_reg   <= RST_RELOCK_TICKS;
            timeout_reg  <= RST_LINK_TIMEOUT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEADER_FIRST:  hdr0_reg     <= cfg_data[HeadWidth-1:0];
                CFG_HEADER_SECOND: hdr1_reg     <= cfg_data[HeadWidth-1:0];
                CFG_HEADER_THIRD:  hdr2_reg     <= cfg_data[HeadWidth-1:0];
                CFG_HIGH_THRESH:   high_thr_reg <= cfg_data[StickWidth-1:0];
                CFG_LOW_THRESH:    low_thr_reg  <= cfg_data[StickWidth-1:0];
                CFG_HOLD_TICKS:    hold_reg     <= cfg_data[HoldWidth-1:0];
                CFG_RELOCK_TICKS:  relock_reg   <= cfg_data[RelockWidth-1:0];
                CFG_LINK_TIMEOUT:  timeout_reg  <= cfg_data[MissWidth-1:0];
                default:           hdr0_reg     <= hdr0_reg;
            endcase
        end
    end

    // input register: take a request whenever the stage is empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_present_reg <= s_tuser;
            in_data_reg    <= s_tdata;
        end
    end

    // parse
    assign accepted = in_present_reg
                   && (in_data_reg[7:0]   == hdr0_reg)
                   && (in_data_reg[15:8]  == hdr1_reg)
                   && (in_data_reg[23:16] == hdr2_reg);

    assign thr_next    = accepted ? in_data_reg[39:24] : thr_reg;
    assign yaw_next    = accepted ? in_data_reg[55:40] : yaw_reg;
    assign pitch_next  = accepted ? in_data_reg[71:56] : pitch_reg;
    assign roll_next   = accepted ? in_data_reg[87:72] : roll_reg;
    assign pd_next     = accepted ? in_data_reg[95:88] : pd_reg;
    assign flag_parsed = flag_reg ^ (accepted && (in_data_reg[103:96] != '0));

    // link watchdog: saturate, then clamp to the timeout once reached
    assign miss_inc = (miss_reg == '1) ? miss_reg : miss_reg + 1'b1;

    always_comb
    begin
        if (accepted)
        begin
            miss_next = '0;
            link      = 1'b1;
        end
        else if (miss_inc >= timeout_reg)
        begin
            miss_next = timeout_reg;
            link      = 1'b0;
        end
        else
        begin
            miss_next = miss_inc;
            link      = 1'b1;
        end
    end

    assign arm_ctrl.step = step;
    assign arm_ctrl.link = link;
    assign arm_ctrl.hi   = thr_next >= high_thr_reg;
    assign arm_ctrl.lo   = thr_next <= low_thr_reg;

    rlac_arm u_arm (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (arm_ctrl),
        .hold_ticks   (hold_reg),
        .relock_ticks (relock_reg),
        .armed        (armed)
    );

    // fix-height survives only while armed on a live link
    assign flag_next = armed && flag_parsed;

    assign out_data_next = {4'b0000, pd_next, roll_next, pitch_next, yaw_next, thr_next,
                            flag_next, armed, link, accepted};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= '0;
            yaw_reg   <= '0;
            pitch_reg <= '0;
            roll_reg  <= '0;
            pd_reg    <= '0;
            flag_reg  <= 1'b0;
            miss_reg  <= RST_MISS_COUNT;
        end
        else if (step)
        begin
            thr_reg   <= thr_next;
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
            pd_reg    <= pd_next;
            flag_reg  <= flag_next;
            miss_reg  <= miss_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_armed_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("armed reported without link");

    a_fix_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("fix-height set while not armed");

    a_accept_keeps_link: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("accepted frame reported with link lost");

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg && (out_data_reg == $past(out_data_next)))
        else $error("result register did not capture the tick");
`endif

endmodule
